// ===== rtl/hfe_pkg.sv =====
package hfe_pkg;

  // window geometry and store sizing
  localparam int WINDOW      = 24;
  localparam int VALUE_BITS  = 18;
  localparam int STORE_DEPTH = WINDOW * WINDOW;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

  // fixed field widths
  localparam int COORD_BITS  = 5;
  localparam int KIND_BITS   = 3;
  localparam int ENTRY_BITS  = 18;
  localparam int FV_BITS     = 23;
  localparam int STATUS_BITS = 2;

  // accumulator holds up to 16 weighted corner values plus sign
  localparam int ACC_BITS    = VALUE_BITS + 6;
  localparam int SAT_BITS    = ACC_BITS + FV_BITS;

  // boundary lines are coordinate sums, one bit wider than a coordinate
  localparam int LINE_BITS   = COORD_BITS + 1;
  localparam int STEP_BITS   = 4;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // feature kinds
  localparam logic [KIND_BITS-1:0] KIND_VPAIR   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_HPAIR   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_COLS3   = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ROWS3   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_CHECKER = 3'd4;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_SIZE  = 2'd2;

  // boundary line selectors, a line value p addresses corner p-1
  localparam int LN_COUNT = 5;
  localparam logic [2:0] LN_START  = 3'd0;
  localparam logic [2:0] LN_HALF   = 3'd1;
  localparam logic [2:0] LN_THIRD1 = 3'd2;
  localparam logic [2:0] LN_THIRD2 = 3'd3;
  localparam logic [2:0] LN_END    = 3'd4;

  typedef struct packed {
    logic                   action;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-1:0]  rect_width;
    logic [COORD_BITS-1:0]  rect_height;
    logic [KIND_BITS-1:0]   feature_kind;
    logic [ENTRY_BITS-1:0]  entry_value;
  } in_t;

  typedef struct packed {
    logic signed [FV_BITS-1:0] feature_value;
    logic [STATUS_BITS-1:0]    status;
  } out_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic last;
  } dp_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_FLUSH,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic [2:0]        row_sel;
    logic [2:0]        col_sel;
    logic signed [3:0] weight;
  } corner_t;

  function automatic corner_t mk_corner(input logic [2:0] r, input logic [2:0] c,
                                        input logic signed [3:0] w);
    corner_t t;
    t.row_sel = r;
    t.col_sel = c;
    t.weight  = w;
    return t;
  endfunction

  // number of corner reads per feature kind
  function automatic logic [STEP_BITS-1:0] corner_count(input logic [KIND_BITS-1:0] kind);
    logic [STEP_BITS-1:0] n;
    case (kind)
      KIND_VPAIR, KIND_HPAIR: n = 4'd6;
      KIND_COLS3, KIND_ROWS3: n = 4'd8;
      KIND_CHECKER:           n = 4'd9;
      default:                n = 4'd1;
    endcase
    return n;
  endfunction

  // corner line pair and weight for each read of each kind
  function automatic corner_t corner_at(input logic [KIND_BITS-1:0] kind,
                                        input logic [STEP_BITS-1:0] step);
    corner_t c;
    c = mk_corner(LN_START, LN_START, 4'sd0);
    case (kind)
      KIND_VPAIR: begin
        case (step)
          4'd0: c = mk_corner(LN_END,   LN_END,    4'sd1);
          4'd1: c = mk_corner(LN_END,   LN_START, -4'sd1);
          4'd2: c = mk_corner(LN_HALF,  LN_END,   -4'sd2);
          4'd3: c = mk_corner(LN_HALF,  LN_START,  4'sd2);
          4'd4: c = mk_corner(LN_START, LN_END,    4'sd1);
          4'd5: c = mk_corner(LN_START, LN_START, -4'sd1);
          default: ;
        endcase
      end
      KIND_HPAIR: begin
        case (step)
          4'd0: c = mk_corner(LN_END,   LN_HALF,   4'sd2);
          4'd1: c = mk_corner(LN_START, LN_HALF,  -4'sd2);
          4'd2: c = mk_corner(LN_END,   LN_START, -4'sd1);
          4'd3: c = mk_corner(LN_START, LN_START,  4'sd1);
          4'd4: c = mk_corner(LN_END,   LN_END,   -4'sd1);
          4'd5: c = mk_corner(LN_START, LN_END,    4'sd1);
          default: ;
        endcase
      end
      KIND_COLS3: begin
        case (step)
          4'd0: c = mk_corner(LN_END,   LN_END,     4'sd1);
          4'd1: c = mk_corner(LN_START, LN_END,    -4'sd1);
          4'd2: c = mk_corner(LN_END,   LN_START,  -4'sd1);
          4'd3: c = mk_corner(LN_START, LN_START,   4'sd1);
          4'd4: c = mk_corner(LN_END,   LN_THIRD2, -4'sd3);
          4'd5: c = mk_corner(LN_START, LN_THIRD2,  4'sd3);
          4'd6: c = mk_corner(LN_END,   LN_THIRD1,  4'sd3);
          4'd7: c = mk_corner(LN_START, LN_THIRD1, -4'sd3);
          default: ;
        endcase
      end
      KIND_ROWS3: begin
        case (step)
          4'd0: c = mk_corner(LN_END,    LN_END,    4'sd1);
          4'd1: c = mk_corner(LN_START,  LN_END,   -4'sd1);
          4'd2: c = mk_corner(LN_END,    LN_START, -4'sd1);
          4'd3: c = mk_corner(LN_START,  LN_START,  4'sd1);
          4'd4: c = mk_corner(LN_THIRD2, LN_END,   -4'sd3);
          4'd5: c = mk_corner(LN_THIRD1, LN_END,    4'sd3);
          4'd6: c = mk_corner(LN_THIRD2, LN_START,  4'sd3);
          4'd7: c = mk_corner(LN_THIRD1, LN_START, -4'sd3);
          default: ;
        endcase
      end
      KIND_CHECKER: begin
        case (step)
          4'd0: c = mk_corner(LN_HALF,  LN_END,    4'sd2);
          4'd1: c = mk_corner(LN_START, LN_END,   -4'sd1);
          4'd2: c = mk_corner(LN_HALF,  LN_HALF,  -4'sd4);
          4'd3: c = mk_corner(LN_START, LN_HALF,   4'sd2);
          4'd4: c = mk_corner(LN_END,   LN_HALF,   4'sd2);
          4'd5: c = mk_corner(LN_END,   LN_START, -4'sd1);
          4'd6: c = mk_corner(LN_HALF,  LN_START,  4'sd2);
          4'd7: c = mk_corner(LN_START, LN_START, -4'sd1);
          4'd8: c = mk_corner(LN_END,   LN_END,   -4'sd1);
          default: ;
        endcase
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/hfe_ctrl.sv =====
module hfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hfe_pkg::dp_stat_t stat,
  output hfe_pkg::dp_cmd_t  cmd
);
  import hfe_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_EVAL) begin
            cmd.capture = 1'b1;
            state_nxt   = S_ISSUE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          cmd.issue = 1'b1;
          if (stat.last) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      // last corner value is summed in this cycle
      S_FLUSH: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/hfe_dp.sv =====
module hfe_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  hfe_pkg::in_t      in_data,
  input  hfe_pkg::dp_cmd_t  cmd,
  output hfe_pkg::dp_stat_t stat,
  output hfe_pkg::out_t     out_data
);
  import hfe_pkg::*;

  localparam logic signed [SAT_BITS-1:0] FV_MAX =
    SAT_BITS'((64'sd1 <<< (FV_BITS - 1)) - 64'sd1);
  localparam logic signed [SAT_BITS-1:0] FV_MIN = -FV_MAX - SAT_BITS'(1);

  // integral store, single port
  logic [VALUE_BITS-1:0] store_mem [STORE_DEPTH];

  logic [LINE_BITS-1:0]  row_line_r [LN_COUNT];
  logic [LINE_BITS-1:0]  col_line_r [LN_COUNT];
  logic [LINE_BITS-1:0]  row_line_nxt [LN_COUNT];
  logic [LINE_BITS-1:0]  col_line_nxt [LN_COUNT];
  logic [KIND_BITS-1:0]  kind_r;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic [STEP_BITS-1:0]  nsteps_r;
  logic [STEP_BITS-1:0]  step_r;

  logic [VALUE_BITS-1:0] rdata_r;
  logic signed [3:0]     wt_d_r;
  logic                  zero_d_r;
  logic                  vld_d_r;
  logic signed [ACC_BITS-1:0] acc_r;
  out_t                  out_data_r;

  logic [COORD_BITS-1:0] w, h, x, y;
  logic [3:0]            w3, h3;
  logic [8:0]            w3_prod, h3_prod;
  logic                  w_by3, h_by3;

  corner_t               cs;
  logic [LINE_BITS-1:0]  rp, cp, rm1, cm1;
  logic                  corner_zero;
  logic [ADDR_BITS-1:0]  raddr, waddr;
  logic                  wr_inside;

  logic signed [ACC_BITS-1:0] val_ext, wt_ext, term;
  logic signed [SAT_BITS-1:0] acc_wide;
  logic signed [FV_BITS-1:0]  fv_sat;

  // capture: boundary lines and status of an evaluate item
  always_comb begin
    x = in_data.pos_x;
    y = in_data.pos_y;
    w = in_data.rect_width;
    h = in_data.rect_height;
    // divide by three as multiply by 11/32, exact below 32
    w3_prod = 9'(w) * 9'd11;
    h3_prod = 9'(h) * 9'd11;
    w3 = w3_prod[8:5];
    h3 = h3_prod[8:5];
    w_by3 = (w == (5'({w3, 1'b0}) + 5'(w3)));
    h_by3 = (h == (5'({h3, 1'b0}) + 5'(h3)));

    row_line_nxt[LN_START]  = LINE_BITS'(y);
    row_line_nxt[LN_HALF]   = LINE_BITS'(y) + LINE_BITS'(h >> 1);
    row_line_nxt[LN_THIRD1] = LINE_BITS'(y) + LINE_BITS'(h3);
    row_line_nxt[LN_THIRD2] = LINE_BITS'(y) + LINE_BITS'({h3, 1'b0});
    row_line_nxt[LN_END]    = LINE_BITS'(y) + LINE_BITS'(h);
    col_line_nxt[LN_START]  = LINE_BITS'(x);
    col_line_nxt[LN_HALF]   = LINE_BITS'(x) + LINE_BITS'(w >> 1);
    col_line_nxt[LN_THIRD1] = LINE_BITS'(x) + LINE_BITS'(w3);
    col_line_nxt[LN_THIRD2] = LINE_BITS'(x) + LINE_BITS'({w3, 1'b0});
    col_line_nxt[LN_END]    = LINE_BITS'(x) + LINE_BITS'(w);

    if (((7'(x) + 7'(w)) > 7'(WINDOW)) || ((7'(y) + 7'(h)) > 7'(WINDOW))) begin
      status_nxt = STAT_RANGE;
    end else if (w == '0 || h == '0) begin
      status_nxt = STAT_SIZE;
    end else begin
      case (in_data.feature_kind)
        KIND_VPAIR:   status_nxt = h[0] ? STAT_SIZE : STAT_OK;
        KIND_HPAIR:   status_nxt = w[0] ? STAT_SIZE : STAT_OK;
        KIND_COLS3:   status_nxt = w_by3 ? STAT_OK : STAT_SIZE;
        KIND_ROWS3:   status_nxt = h_by3 ? STAT_OK : STAT_SIZE;
        KIND_CHECKER: status_nxt = (h[0] || w[0]) ? STAT_SIZE : STAT_OK;
        default:      status_nxt = STAT_SIZE;
      endcase
    end
  end

  // corner address for the current read step
  always_comb begin
    cs  = corner_at(kind_r, step_r);
    rp  = row_line_r[cs.row_sel];
    cp  = col_line_r[cs.col_sel];
    rm1 = rp - LINE_BITS'(1);
    cm1 = cp - LINE_BITS'(1);
    // line zero is the row or column above or left of the window
    corner_zero = (rp == '0) || (cp == '0);
    raddr = ADDR_BITS'(32'(rm1) * WINDOW + 32'(cm1));
    waddr = ADDR_BITS'(32'(y) * WINDOW + 32'(x));
    wr_inside = (32'(x) < WINDOW) && (32'(y) < WINDOW);
  end

  always_ff @(posedge clk) begin
    if (cmd.write && wr_inside) begin
      store_mem[waddr] <= VALUE_BITS'(in_data.entry_value);
    end
    if (cmd.issue) begin
      rdata_r <= store_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_line_r <= row_line_nxt;
      col_line_r <= col_line_nxt;
      kind_r     <= in_data.feature_kind;
      status_r   <= status_nxt;
      nsteps_r   <= corner_count(in_data.feature_kind);
    end
    wt_d_r   <= cs.weight;
    zero_d_r <= corner_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= cmd.issue;
      if (cmd.capture) begin
        step_r <= '0;
      end else if (cmd.issue) begin
        step_r <= step_r + STEP_BITS'(1);
      end
    end
  end

  // weighted accumulate of the registered corner value
  always_comb begin
    val_ext  = ACC_BITS'({1'b0, rdata_r});
    wt_ext   = ACC_BITS'(wt_d_r);
    term     = zero_d_r ? '0 : val_ext * wt_ext;
    acc_wide = SAT_BITS'(acc_r);
    if (acc_wide > FV_MAX) begin
      fv_sat = FV_BITS'(FV_MAX);
    end else if (acc_wide < FV_MIN) begin
      fv_sat = FV_BITS'(FV_MIN);
    end else begin
      fv_sat = FV_BITS'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_r <= '0;
    end else if (vld_d_r) begin
      acc_r <= acc_r + term;
    end
    if (cmd.load_out) begin
      out_data_r.status        <= status_r;
      out_data_r.feature_value <= (status_r != STAT_OK) ? '0 : fv_sat;
    end
  end

  assign stat.err  = (status_r != STAT_OK);
  assign stat.last = (step_r == (nsteps_r - STEP_BITS'(1)));
  assign out_data  = out_data_r;

endmodule

// ===== rtl/haar_feature_evaluator.sv =====
// haar feature evaluator over a 24x24 integral image. a write transaction
// (action 0) stores one integral entry in a single-ported store; writes
// outside the window are dropped and give no result. an evaluate
// transaction (action 1) returns one result: the feature sum and a status
// (0 ok, 1 rectangle leaves the window, 2 size illegal for the kind, value
// then zero). an evaluate makes n corner reads, n being 6 for the pairs,
// 8 for the thirds, 9 for the checkerboard, 0 when rejected; the single
// store port does one corner read a cycle. a result waits in an output
// register and the next transaction is taken once it has been loaded
// there. entries must be written before any feature reads them.
module haar_feature_evaluator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hfe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hfe_pkg::out_t out_data
);
  import hfe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: capture, corner reads, flush, result load
  hfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, boundary lines, weighted accumulator and output register
  hfe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // rejected rectangles always report a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STAT_OK)) |-> (out_data.feature_value == '0))
    else $error("nonzero feature value with error status");

  // an evaluate transaction keeps the input side closed while it runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.action == ACT_EVAL)) |=> !in_ready)
    else $error("input taken during an evaluate");

  // a write never creates a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.action == ACT_WRITE) && !out_valid) |=> !out_valid)
    else $error("result after a write transaction");

  // corner reads only happen while the input side is closed
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_ready)
    else $error("corner read while idle");

endmodule
